FILE: rtl/sorted_key_table_insert_list_assert.svh
// Assertion macros shared by the sorted key table RTL.
// Simulation builds get concurrent assertions; synthesis builds get empty bodies.
`ifndef SORTED_KEY_TABLE_INSERT_LIST_ASSERT_SVH
`define SORTED_KEY_TABLE_INSERT_LIST_ASSERT_SVH

`ifndef SYNTHESIS
// The property must hold at every clock edge outside reset.
`define SKTI_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// When the antecedent holds, the consequent must hold in the following cycle.
`define SKTI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SKTI_ASSERT(lbl, clk, rst, prop)
`define SKTI_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/skti_pkg.sv
// Shared types and constants for the sorted key table.
// Used by the controller, the datapath and the top level; depends on nothing.
package skti_pkg;

   localparam int KEY_W       = 64;
   localparam int GRADE_W     = 8;
   localparam int MAX_RESULTS = 16;
   localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

   // Operation carried by each request beat.
   typedef enum logic [1:0] {
      OP_ADD        = 2'd0,
      OP_LIST_GRADE = 2'd1,
      OP_LIST_ALL   = 2'd2,
      OP_NONE       = 2'd3
   } opcode_type;

   // Add outcome reported in the response status field.
   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_DUP  = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   // What the output register is loaded with.
   typedef enum logic [1:0] {
      EMIT_ADD   = 2'd0,
      EMIT_ENTRY = 2'd1,
      EMIT_LAST  = 2'd2,
      EMIT_EMPTY = 2'd3
   } emit_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic     latch;
      logic     add_write;
      logic     rotate;
      logic     pend_load;
      logic     emit;
      emit_type emit_kind;
      logic     match_all;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic       out_free;
      logic       cell_match;
   } stat_type;

endpackage

FILE: rtl/skti_ctrl.sv
// Controller state machine of the sorted key table.
// Depends on skti_pkg and the assertion macro header.
`include "sorted_key_table_insert_list_assert.svh"

module skti_ctrl
   import skti_pkg::*;
#(
   parameter int MAX_ENTRIES = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  opcode_type                           req_op,
   input  logic [$clog2(MAX_ENTRIES + 1) - 1:0] entry_count,
   input  stat_type                             stat,
   output cmd_type                              cmd
);

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_ADD,
      S_SCAN,
      S_FINISH
   } state_type;

   state_type              state_ff, state_in;
   logic [IDX_W - 1:0]     idx_ff, idx_in;
   logic [RES_CNT_W - 1:0] nres_ff, nres_in;
   logic                   pend_v_ff, pend_v_in;
   logic                   all_ff, all_in;
   logic                   hit;
   logic                   stall;

   assign req_ready = (state_ff == S_IDLE);

   // A scan step hits when the entry at the head cell is live, matches and fits the cap.
   assign hit = (CNT_W'(idx_ff) < entry_count) && stat.cell_match &&
                (nres_ff < RES_CNT_W'(MAX_RESULTS));
   // A second hit must push the held entry out, which needs a free output register.
   assign stall = hit && pend_v_ff && !stat.out_free;

   // Next state and commands.
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      nres_in       = nres_ff;
      pend_v_in     = pend_v_ff;
      all_in        = all_ff;
      cmd           = '0;
      cmd.match_all = all_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               unique case (req_op)
                  OP_ADD: begin
                     state_in = S_ADD;
                  end
                  OP_LIST_GRADE, OP_LIST_ALL: begin
                     state_in  = S_SCAN;
                     idx_in    = '0;
                     nres_in   = '0;
                     pend_v_in = 1'b0;
                     all_in    = (req_op == OP_LIST_ALL);
                  end
                  OP_NONE: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_ADD: begin
            if (stat.out_free) begin
               cmd.add_write = 1'b1;
               cmd.emit      = 1'b1;
               cmd.emit_kind = EMIT_ADD;
               state_in      = S_IDLE;
            end
         end
         S_SCAN: begin
            if (!stall) begin
               cmd.rotate = 1'b1;
               if (hit) begin
                  cmd.pend_load = 1'b1;
                  pend_v_in     = 1'b1;
                  nres_in       = nres_ff + RES_CNT_W'(1);
                  if (pend_v_ff) begin
                     cmd.emit      = 1'b1;
                     cmd.emit_kind = EMIT_ENTRY;
                  end
               end
               if (idx_ff == IDX_W'(MAX_ENTRIES - 1)) begin
                  state_in = S_FINISH;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = pend_v_ff ? EMIT_LAST : EMIT_EMPTY;
               state_in      = S_IDLE;
            end
         end
      endcase
   end

   // State and scan bookkeeping.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         idx_ff    <= '0;
         nres_ff   <= '0;
         pend_v_ff <= 1'b0;
         all_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         idx_ff    <= idx_in;
         nres_ff   <= nres_in;
         pend_v_ff <= pend_v_in;
         all_ff    <= all_in;
      end
   end

   `SKTI_ASSERT(a_nres_capped, clock, reset, nres_ff <= RES_CNT_W'(MAX_RESULTS))
   `SKTI_ASSERT_NEXT(a_stall_holds_idx, clock, reset, state_ff == S_SCAN && !cmd.rotate, idx_ff == $past(idx_ff))
   `SKTI_ASSERT_NEXT(a_add_done, clock, reset, state_ff == S_ADD && stat.out_free, state_ff == S_IDLE)

endmodule

FILE: rtl/skti_dpath.sv
// Datapath of the sorted key table: the sorted cell chain, the request latch,
// the held list entry and the output register. Depends on skti_pkg and the macro header.
`include "sorted_key_table_insert_list_assert.svh"

module skti_dpath
   import skti_pkg::*;
#(
   parameter int MAX_ENTRIES = 16,
   parameter int NAME_BYTES  = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cmd_type                              cmd,
   output stat_type                             stat,
   output logic [$clog2(MAX_ENTRIES + 1) - 1:0] entry_count,
   input  logic [KEY_W - 1:0]                   req_name,
   input  logic [GRADE_W - 1:0]                 req_grade,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [1:0]                           rsp_status,
   output logic                                 rsp_has_entry,
   output logic [GRADE_W - 1:0]                 rsp_grade,
   output logic [KEY_W - 1:0]                   rsp_name,
   output logic                                 rsp_last
);

   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
   localparam int NAME_W = 8 * NAME_BYTES;

   logic [GRADE_W - 1:0] grade_ff [MAX_ENTRIES];
   logic [NAME_W - 1:0]  name_ff  [MAX_ENTRIES];
   logic [GRADE_W - 1:0] grade_in [MAX_ENTRIES];
   logic [NAME_W - 1:0]  name_in  [MAX_ENTRIES];
   logic [GRADE_W - 1:0] up_grade [MAX_ENTRIES];
   logic [NAME_W - 1:0]  up_name  [MAX_ENTRIES];
   logic [GRADE_W - 1:0] dn_grade [MAX_ENTRIES];
   logic [NAME_W - 1:0]  dn_name  [MAX_ENTRIES];

   logic [MAX_ENTRIES - 1:0] live_c, dup_c, before_c, prev_before_c;
   logic [CNT_W - 1:0]       count_ff, count_in;
   logic [KEY_W - 1:0]       norm_key;
   logic [NAME_W - 1:0]      key_name_ff;
   logic [GRADE_W - 1:0]     key_grade_ff;
   logic [GRADE_W - 1:0]     pend_grade_ff;
   logic [NAME_W - 1:0]      pend_name_ff;
   logic                     ins_ok;
   status_type               add_status;

   logic                 rsp_valid_ff;
   logic [1:0]           rsp_status_ff;
   logic                 rsp_has_ff;
   logic [GRADE_W - 1:0] rsp_grade_ff;
   logic [KEY_W - 1:0]   rsp_name_ff;
   logic                 rsp_last_ff;

   // Key normalization: bytes past the first zero byte or past NAME_BYTES are cleared.
   always_comb begin
      logic alive;
      alive    = 1'b1;
      norm_key = '0;
      for (int b = 0; b < 8; b++) begin
         if (b >= NAME_BYTES || req_name[KEY_W - 1 - 8 * b -: 8] == 8'd0) begin
            alive = 1'b0;
         end
         if (alive) begin
            norm_key[KEY_W - 1 - 8 * b -: 8] = req_name[KEY_W - 1 - 8 * b -: 8];
         end
      end
   end

   // Request latch.
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         key_name_ff  <= norm_key[KEY_W - 1 -: NAME_W];
         key_grade_ff <= req_grade;
      end
   end

   // Per-cell compare, neighbor wiring and next value.
   for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
      assign live_c[k]   = (CNT_W'(k) < count_ff);
      assign dup_c[k]    = live_c[k] && (name_ff[k] == key_name_ff);
      assign before_c[k] = !live_c[k] ||
                           ({key_grade_ff, key_name_ff} < {grade_ff[k], name_ff[k]});

      if (k == MAX_ENTRIES - 1) begin : g_wrap
         assign up_grade[k] = grade_ff[0];
         assign up_name[k]  = name_ff[0];
      end else begin : g_up
         assign up_grade[k] = grade_ff[k + 1];
         assign up_name[k]  = name_ff[k + 1];
      end

      if (k == 0) begin : g_head
         assign dn_grade[k]      = key_grade_ff;
         assign dn_name[k]       = key_name_ff;
         assign prev_before_c[k] = 1'b0;
      end else begin : g_body
         assign dn_grade[k]      = grade_ff[k - 1];
         assign dn_name[k]       = name_ff[k - 1];
         assign prev_before_c[k] = before_c[k - 1];
      end

      // Rotate for a list scan, or open a slot and insert on an add.
      always_comb begin
         grade_in[k] = grade_ff[k];
         name_in[k]  = name_ff[k];
         if (cmd.rotate) begin
            grade_in[k] = up_grade[k];
            name_in[k]  = up_name[k];
         end else if (ins_ok && before_c[k]) begin
            if (!prev_before_c[k]) begin
               grade_in[k] = key_grade_ff;
               name_in[k]  = key_name_ff;
            end else begin
               grade_in[k] = dn_grade[k];
               name_in[k]  = dn_name[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_ENTRIES; k++) begin
         grade_ff[k] <= grade_in[k];
         name_ff[k]  <= name_in[k];
      end
   end

   // Add outcome: a duplicate wins over a full table.
   always_comb begin
      priority if (|dup_c) begin
         add_status = ST_DUP;
      end else if (count_ff == CNT_W'(MAX_ENTRIES)) begin
         add_status = ST_FULL;
      end else begin
         add_status = ST_OK;
      end
   end

   assign ins_ok   = cmd.add_write && (add_status == ST_OK);
   assign count_in = ins_ok ? count_ff + CNT_W'(1) : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Held list entry, taken from the head cell.
   always_ff @(posedge clock) begin
      if (cmd.pend_load) begin
         pend_grade_ff <= grade_ff[0];
         pend_name_ff  <= name_ff[0];
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         unique case (cmd.emit_kind)
            EMIT_ADD: begin
               rsp_status_ff <= add_status;
               rsp_has_ff    <= 1'b0;
               rsp_grade_ff  <= '0;
               rsp_name_ff   <= '0;
               rsp_last_ff   <= 1'b1;
            end
            EMIT_ENTRY, EMIT_LAST: begin
               rsp_status_ff <= ST_OK;
               rsp_has_ff    <= 1'b1;
               rsp_grade_ff  <= pend_grade_ff;
               rsp_name_ff   <= KEY_W'(pend_name_ff) << (KEY_W - NAME_W);
               rsp_last_ff   <= (cmd.emit_kind == EMIT_LAST);
            end
            EMIT_EMPTY: begin
               rsp_status_ff <= ST_OK;
               rsp_has_ff    <= 1'b0;
               rsp_grade_ff  <= '0;
               rsp_name_ff   <= '0;
               rsp_last_ff   <= 1'b1;
            end
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_has_entry = rsp_has_ff;
   assign rsp_grade     = rsp_grade_ff;
   assign rsp_name      = rsp_name_ff;
   assign rsp_last      = rsp_last_ff;

   assign entry_count     = count_ff;
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;
   assign stat.cell_match = cmd.match_all || (grade_ff[0] == key_grade_ff);

   `SKTI_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(MAX_ENTRIES))
   `SKTI_ASSERT(a_no_rotate_on_add, clock, reset, !(cmd.rotate && cmd.add_write))
   `SKTI_ASSERT(a_no_overwrite, clock, reset, !(rsp_valid_ff && !rsp_ready && cmd.emit))

endmodule

FILE: rtl/sorted_key_table_insert_list.sv
// Top level of the sorted key table: stream ports, controller and datapath.
// Depends on skti_pkg, skti_ctrl and skti_dpath.
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  tdata: name_key, grade; tuser: opcode
//   rsp      out  rsp_tvalid/rsp_tready  tdata: out_grade, out_name; tuser: status,
//                                        has_entry; tlast: last
//
// An add latches the beat, then compares and inserts in the cell chain once the output is free.
// A list latches the beat, then the chain rotates one cell a cycle past the head compare unless
// a stall holds it, and returns to its order when the scan ends; results leave at most one a cycle.
// A stalled response holds the scan in place; a new request is taken only between items.
// Synchronous reset empties the table at once; there is no clearing pass.

module sorted_key_table_insert_list
   import skti_pkg::*;
#(
   parameter int MAX_ENTRIES = 16,
   parameter int NAME_BYTES  = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // name_key [63:0], grade [71:64]
   input  logic [1:0]  req_tuser,   // opcode [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // out_grade [7:0], out_name [71:8]
   output logic [2:0]  rsp_tuser,   // status [1:0], has_entry [2]
   output logic        rsp_tlast
);

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   cmd_type              cmd;
   stat_type             stat;
   logic [CNT_W - 1:0]   entry_count;
   logic [1:0]           rsp_status;
   logic                 rsp_has_entry;
   logic [GRADE_W - 1:0] rsp_grade;
   logic [KEY_W - 1:0]   rsp_name;

   skti_ctrl #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_op      (opcode_type'(req_tuser)),
      .entry_count (entry_count),
      .stat        (stat),
      .cmd         (cmd)
   );

   skti_dpath #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .NAME_BYTES  (NAME_BYTES)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .entry_count   (entry_count),
      .req_name      (req_tdata[63:0]),
      .req_grade     (req_tdata[71:64]),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_status    (rsp_status),
      .rsp_has_entry (rsp_has_entry),
      .rsp_grade     (rsp_grade),
      .rsp_name      (rsp_name),
      .rsp_last      (rsp_tlast)
   );

   // Response beat packing.
   assign rsp_tdata = {rsp_name, rsp_grade};
   assign rsp_tuser = {rsp_has_entry, rsp_status};

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the sorted key table: adds, per-grade lists and full lists.
// Depends on skti_pkg and sorted_key_table_insert_list; needs no files or arguments.

module tb_top;
   import skti_pkg::*;

   localparam int MAX_ENTRIES  = 16;
   localparam int NAME_BYTES   = 8;
   localparam int RANDOM_ITEMS = 125;
   localparam int TAIL_ITEMS   = 30;
   localparam int CYCLE_LIMIT  = 300000;

   // One request beat as the sender sees it.
   typedef struct {
      opcode_type  op;
      logic [63:0] key;
      logic [7:0]  grade;
      bit          drain;
   } roster_req_type;

   // One response beat as the block should return it.
   typedef struct {
      status_type  status;
      logic        has_entry;
      logic [7:0]  grade;
      logic [63:0] name;
      logic        last;
   } roster_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;   // name_key [63:0], grade [71:64]
   logic [1:0]  req_tuser = '0;   // opcode [1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;        // out_grade [7:0], out_name [71:8]
   logic [2:0]  rsp_tuser;        // status [1:0], has_entry [2]
   logic        rsp_tlast;

   roster_req_type req_pending_q[$];
   roster_rsp_type rsp_expect_q[$];
   roster_req_type cur_req;

   // Shadow copy of the sorted table.
   logic [7:0]  roster_grade[MAX_ENTRIES];
   logic [63:0] roster_name[MAX_ENTRIES];
   int          roster_count = 0;

   int total_items = 0;
   int beats_sent = 0;
   int req_gap = 0;
   int rsp_gap = 0;
   int mismatches = 0;
   int cycle_cnt = 0;
   int n_added = 0, n_dup = 0, n_full = 0, n_lists = 0, n_empty = 0, n_rsp_seen = 0;

   sorted_key_table_insert_list #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .NAME_BYTES  (NAME_BYTES)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Free-running clock, 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // A name ends at its first zero byte; only NAME_BYTES leading bytes count.
   function automatic logic [63:0] trim_name_key(input logic [63:0] key);
      logic [63:0] res;
      logic [7:0]  b;
      res = '0;
      for (int i = 0; i < 8 && i < NAME_BYTES; i++) begin
         b = key[56 - 8 * i +: 8];
         if (b == 8'h00)
            break;
         res[56 - 8 * i +: 8] = b;
      end
      return res;
   endfunction

   // Applies one accepted request to the shadow table and queues its responses.
   task automatic predict_roster_op(input roster_req_type rq);
      logic [63:0]    nk;
      roster_rsp_type r;
      int             pos;
      int             n;
      bit             dup;
      nk = trim_name_key(rq.key);
      r.status = ST_OK;
      r.has_entry = 1'b0;
      r.grade = '0;
      r.name = '0;
      r.last = 1'b1;
      case (rq.op)
         OP_ADD: begin
            dup = 1'b0;
            for (int i = 0; i < roster_count; i++)
               if (roster_name[i] == nk)
                  dup = 1'b1;
            if (dup) begin
               r.status = ST_DUP;
               n_dup++;
            end else if (roster_count >= MAX_ENTRIES) begin
               r.status = ST_FULL;
               n_full++;
            end else begin
               pos = roster_count;
               for (int i = 0; i < roster_count; i++) begin
                  if (rq.grade < roster_grade[i] ||
                      (rq.grade == roster_grade[i] && nk < roster_name[i])) begin
                     pos = i;
                     break;
                  end
               end
               for (int i = roster_count; i > pos; i--) begin
                  roster_grade[i] = roster_grade[i - 1];
                  roster_name[i] = roster_name[i - 1];
               end
               roster_grade[pos] = rq.grade;
               roster_name[pos] = nk;
               roster_count++;
               n_added++;
            end
            rsp_expect_q.push_back(r);
         end
         OP_LIST_GRADE, OP_LIST_ALL: begin
            n = 0;
            n_lists++;
            for (int i = 0; i < roster_count && n < MAX_RESULTS; i++) begin
               if (rq.op == OP_LIST_ALL || roster_grade[i] == rq.grade) begin
                  r.has_entry = 1'b1;
                  r.grade = roster_grade[i];
                  r.name = roster_name[i];
                  r.last = 1'b0;
                  rsp_expect_q.push_back(r);
                  n++;
               end
            end
            if (n == 0) begin
               n_empty++;
               rsp_expect_q.push_back(r);
            end else begin
               rsp_expect_q[rsp_expect_q.size() - 1].last = 1'b1;
            end
         end
         default: ;   // unused opcode: no state change, no response
      endcase
   endtask

   task automatic queue_req(input opcode_type op, input logic [63:0] key,
                            input logic [7:0] grade, input bit drain);
      roster_req_type rq;
      rq.op = op;
      rq.key = key;
      rq.grade = grade;
      rq.drain = drain;
      req_pending_q.push_back(rq);
      total_items++;
   endtask

   task automatic check_field(input string what, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: response %s mismatch, expected %0h, actual %0h",
                  $time, what, want, got);
         mismatches++;
      end
   endtask

   // Request driver: presents queued beats, with random gaps until the tail.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_roster_op(cur_req);
            beats_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (req_pending_q.size() == 0 ||
                         (req_pending_q[0].drain && rsp_expect_q.size() != 0)) begin
               req_tvalid <= 1'b0;
            end else begin
               cur_req = req_pending_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {cur_req.grade, cur_req.key};
               req_tuser <= cur_req.op;
               if (req_pending_q.size() > TAIL_ITEMS && $urandom_range(0, 3) == 0)
                  req_gap = $urandom_range(1, 14);
            end
         end
      end
   end

   // Response monitor: checks each beat against the oldest expectation.
   always @(posedge clock) begin
      roster_rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            n_rsp_seen++;
            if (rsp_expect_q.size() == 0) begin
               $display("%0t: response beat with nothing expected, actual tdata %0h tuser %0h",
                        $time, rsp_tdata, rsp_tuser);
               mismatches++;
            end else begin
               want = rsp_expect_q.pop_front();
               check_field("status", 64'(want.status), 64'(rsp_tuser[1:0]));
               check_field("has_entry", 64'(want.has_entry), 64'(rsp_tuser[2]));
               check_field("grade", 64'(want.grade), 64'(rsp_tdata[7:0]));
               check_field("name", want.name, rsp_tdata[71:8]);
               check_field("last", 64'(want.last), 64'(rsp_tlast));
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (req_pending_q.size() > TAIL_ITEMS && $urandom_range(0, 4) == 0)
               rsp_gap = $urandom_range(1, 14);
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      logic [63:0] used_keys[$];
      logic [7:0]  grade_set[4];
      logic [63:0] key;
      logic [7:0]  grade;
      opcode_type  op;
      int          counted;
      int          sel;
      int          mode;

      grade_set[0] = 8'd0;
      grade_set[1] = 8'd7;
      grade_set[2] = 8'd128;
      grade_set[3] = 8'd255;

      // Directed: empty lists, extreme keys and grades, zero-byte names, duplicates.
      queue_req(OP_LIST_ALL, 64'h0, 8'd0, 1'b0);
      queue_req(OP_LIST_GRADE, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0, 1'b0);
      queue_req(OP_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 8'd255, 1'b0);
      queue_req(OP_ADD, 64'h0, 8'd0, 1'b0);
      queue_req(OP_ADD, 64'h4142_0043_4445_4600, 8'd7, 1'b0);
      // Same name once truncated at its zero byte, so it is a duplicate.
      queue_req(OP_ADD, 64'h4142_00FF_0000_0001, 8'd9, 1'b0);
      // Leading zero byte makes an empty name, which is already present.
      queue_req(OP_ADD, 64'h0012_3456_789A_BCDE, 8'd3, 1'b0);
      queue_req(OP_NONE, 64'hA5A5_5A5A_A5A5_5A5A, 8'd7, 1'b0);
      queue_req(OP_ADD, 64'h4142_4300_0000_0000, 8'd7, 1'b0);
      queue_req(OP_ADD, 64'h4141_4141_4141_4141, 8'd7, 1'b0);
      queue_req(OP_LIST_GRADE, 64'h0, 8'd7, 1'b0);
      queue_req(OP_LIST_GRADE, 64'h0, 8'd255, 1'b0);
      queue_req(OP_LIST_GRADE, 64'h0, 8'd0, 1'b0);
      queue_req(OP_LIST_GRADE, 64'h0, 8'd200, 1'b0);
      queue_req(OP_LIST_ALL, 64'hFFFF_FFFF_FFFF_FFFF, 8'd255, 1'b1);
      queue_req(OP_ADD, 64'h8000_0000_0000_0001, 8'd128, 1'b1);
      used_keys.push_back(64'hFFFF_FFFF_FFFF_FFFF);
      used_keys.push_back(64'h4142_4300_0000_0000);
      used_keys.push_back(64'h4141_4141_4141_4141);

      // Random: mostly adds and lists, names often reused to hit duplicates.
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         sel = $urandom_range(0, 19);
         mode = $urandom_range(0, 7);
         if (sel < 9)
            op = OP_ADD;
         else if (sel < 14)
            op = OP_LIST_GRADE;
         else if (sel < 19)
            op = OP_LIST_ALL;
         else
            op = OP_NONE;
         if (mode < 2) begin
            key = used_keys[$urandom_range(0, used_keys.size() - 1)];
         end else begin
            key = {$urandom, $urandom};
            if (mode == 2)
               key[8 * $urandom_range(0, 7) +: 8] = 8'h00;
            else if (mode == 3)
               key = key & ~(64'hFFFF_FFFF_FFFF_FFFF >> (8 * $urandom_range(1, 7)));
         end
         if ($urandom_range(0, 3) == 0)
            grade = 8'($urandom_range(0, 255));
         else
            grade = grade_set[$urandom_range(0, 3)];
         if (op == OP_ADD)
            used_keys.push_back(key);
         queue_req(op, key, grade, $urandom_range(0, 29) == 0);
         if (op != OP_NONE)
            counted++;
      end

      // By now the table is full: a fresh name and a known one.
      queue_req(OP_ADD, 64'h5A5A_5A5A_5A5A_5A5B, 8'd1, 1'b0);
      queue_req(OP_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 8'd2, 1'b0);
      queue_req(OP_LIST_ALL, 64'h0, 8'd0, 1'b0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (beats_sent < total_items)
         @(posedge clock);
      while (rsp_expect_q.size() != 0)
         @(posedge clock);
      repeat (MAX_ENTRIES + 20) @(posedge clock);

      $display("Covered %0d request beats: %0d adds stored, %0d duplicates, %0d full rejects,",
               beats_sent, n_added, n_dup, n_full);
      $display("and %0d lists (%0d empty), with %0d response beats checked.",
               n_lists, n_empty, n_rsp_seen);
      if (mismatches == 0 && rsp_expect_q.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
